[hw/rtl/ptd_pkg.sv]
package ptd_pkg;

    localparam int PERIOD_W    = 16;
    localparam int MAX_RESULTS = 8;
    localparam int FOUND_W     = 4;
    localparam int TIDX_W      = 3;
    localparam int BITCNT_W    = 4;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME  = 3'd3,
        OP_TICK    = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_NONE_DUE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OCCUPIED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_EVAL,
        S_NEXT,
        S_PUSH
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [TIDX_W-1:0]  task_index;
        status_t            status;
        logic               last;
    } result_t;

endpackage

[hw/rtl/ptd_req_if.sv]
interface ptd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  slot;
    logic [15:0] period;

    modport source (output valid, output opcode, output slot, output period, input ready);
    modport sink   (input valid, input opcode, input slot, input period, output ready);
endinterface

[hw/rtl/ptd_rsp_if.sv]
interface ptd_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] task_index;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output kind, output task_index, output status, output last,
                    input ready);
    modport sink   (input valid, input kind, input task_index, input status, input last,
                    output ready);
endinterface

[hw/rtl/periodic_task_dispatcher.sv]
// Periodic task dispatcher: a table of TASK_SLOTS task slots, slot 0 first.
// req carries one command per transaction: create, delete, suspend, resume
// or tick. rsp returns results; last marks the final result of a command.
// Management commands give one status result, held in res_reg and then the output register.
// A tick bumps the 16-bit tick counter and then scans the slots in order.
// Each valid, resumed slot takes a period memory read, a restoring remainder
// in the one shared subtract/compare unit, and an evaluate step; other slots
// take only the read and next-slot steps. Each result takes a push step, which
// waits while the output is stalled. Due slots come out as dispatch results
// (at most 8 per tick); with none due, one none-due result is sent.
// req.ready is high only while the sequencer is idle; one command at a time.
// rsp has an output register, so a command is accepted while the previous
// result still waits. If the receiver stalls, the sequencer holds the next
// result and waits; nothing is dropped.
// Reset clears all slot flags, the tick counter and the output register.
// The period memory needs no clearing: a slot's period is written on create
// before the slot can be valid.
module periodic_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    ptd_req_if.sink    req,
    ptd_rsp_if.source  rsp
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [7:0]    SLOTS8    = 8'(TASK_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);

    state_t                 state_reg, state_next;
    logic [TASK_SLOTS-1:0]  valid_reg, valid_next;
    logic [TASK_SLOTS-1:0]  resumed_reg, resumed_next;
    logic [PERIOD_W-1:0]    tick_reg, tick_next;
    logic [SW-1:0]          scan_reg, scan_next;
    logic [FOUND_W-1:0]     found_reg, found_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [SW-1:0]          pend_idx_reg, pend_idx_next;
    logic [PERIOD_W-1:0]    rem_reg, rem_next;
    logic [PERIOD_W-1:0]    div_sh_reg, div_sh_next;
    logic [BITCNT_W-1:0]    bit_reg, bit_next;
    result_t                res_reg, res_next;
    result_t                out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [PERIOD_W-1:0]    period_mem [TASK_SLOTS];
    logic [PERIOD_W-1:0]    period_rd_reg;
    logic                   mem_we;

    logic [SW-1:0]          slot_idx;
    logic                   out_free;
    logic [PERIOD_W:0]      trial;
    logic [PERIOD_W:0]      trial_diff;
    logic                   due;

    assign slot_idx   = req.slot[SW-1:0];
    assign out_free   = !out_valid_reg || rsp.ready;
    assign trial      = {rem_reg, div_sh_reg[PERIOD_W-1]};
    assign trial_diff = trial - {1'b0, period_rd_reg};
    assign due        = (period_rd_reg != '0) && (rem_reg == '0);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_reg.kind;
    assign rsp.task_index = out_reg.task_index;
    assign rsp.status     = out_reg.status;
    assign rsp.last       = out_reg.last;

    // period store: one write port (create), one registered read at the scan slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            period_mem[slot_idx] <= req.period;
        end
        period_rd_reg <= period_mem[scan_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            resumed_reg    <= '0;
            tick_reg       <= '0;
            scan_reg       <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            rem_reg        <= '0;
            div_sh_reg     <= '0;
            bit_reg        <= '0;
            res_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            resumed_reg    <= resumed_next;
            tick_reg       <= tick_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            rem_reg        <= rem_next;
            div_sh_reg     <= div_sh_next;
            bit_reg        <= bit_next;
            res_reg        <= res_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        resumed_next    = resumed_reg;
        tick_next       = tick_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        rem_next        = rem_reg;
        div_sh_next     = div_sh_reg;
        bit_next        = bit_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        mem_we          = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next.kind       = KIND_STATUS;
                    res_next.task_index = req.slot[TIDX_W-1:0];
                    res_next.status     = ST_OK;
                    res_next.last       = 1'b1;
                    if (req.opcode == OP_TICK)
                    begin
                        tick_next       = tick_reg + 1'b1;
                        scan_next       = '0;
                        found_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_READ;
                    end
                    else if (req.opcode > OP_TICK)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (req.slot >= SLOTS8)
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                        unique case (opcode_t'(req.opcode))
                            OP_CREATE:
                            begin
                                if (valid_reg[slot_idx])
                                begin
                                    res_next.status = ST_OCCUPIED;
                                end
                                else
                                begin
                                    valid_next[slot_idx]   = 1'b1;
                                    resumed_next[slot_idx] = 1'b1;
                                    mem_we                 = 1'b1;
                                end
                            end
                            OP_DELETE:  valid_next[slot_idx]   = 1'b0;
                            OP_SUSPEND: resumed_next[slot_idx] = 1'b0;
                            OP_RESUME:  resumed_next[slot_idx] = 1'b1;
                            default:    state_next = S_IDLE;
                        endcase
                    end
                end
            end

            S_READ:
            begin
                // period_rd_reg becomes valid for this slot on the next cycle
                if (valid_reg[scan_reg] && resumed_reg[scan_reg])
                begin
                    rem_next    = '0;
                    div_sh_next = tick_reg;
                    bit_next    = '0;
                    state_next  = S_DIV;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end

            S_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                if (trial >= {1'b0, period_rd_reg})
                begin
                    rem_next = trial_diff[PERIOD_W-1:0];
                end
                else
                begin
                    rem_next = trial[PERIOD_W-1:0];
                end
                div_sh_next = {div_sh_reg[PERIOD_W-2:0], 1'b0};
                bit_next    = bit_reg + 1'b1;
                if (bit_reg == BITCNT_W'(PERIOD_W - 1))
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_NEXT;
                if (due)
                begin
                    found_next      = found_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_reg;
                    // earlier due slot is now known not to be the last one
                    if (pend_valid_reg)
                    begin
                        res_next.kind       = KIND_DISPATCH;
                        res_next.task_index = TIDX_W'(pend_idx_reg);
                        res_next.status     = ST_OK;
                        res_next.last       = 1'b0;
                        state_next          = S_PUSH;
                    end
                end
            end

            S_NEXT:
            begin
                if (scan_reg == LAST_SLOT || found_reg == FOUND_W'(MAX_RESULTS))
                begin
                    res_next.status = ST_OK;
                    res_next.last   = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next.kind       = KIND_DISPATCH;
                        res_next.task_index = TIDX_W'(pend_idx_reg);
                    end
                    else
                    begin
                        res_next.kind       = KIND_NONE_DUE;
                        res_next.task_index = '0;
                    end
                    state_next = S_PUSH;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_READ;
                end
            end

            S_PUSH:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = res_reg.last ? S_IDLE : S_NEXT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    property p_tick_counts;
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.opcode == OP_TICK)
            |=> (tick_reg == $past(tick_reg) + 1'b1);
    endproperty
    a_tick_counts: assert property (p_tick_counts)
        else $error("tick counter did not advance on tick");

    property p_found_bound;
        @(posedge clk) disable iff (!rst_n)
        found_reg <= FOUND_W'(MAX_RESULTS);
    endproperty
    a_found_bound: assert property (p_found_bound)
        else $error("more due slots found than results allowed");

    property p_none_due_last;
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == KIND_NONE_DUE)
            |-> (rsp.last && rsp.task_index == '0 && rsp.status == ST_OK);
    endproperty
    a_none_due_last: assert property (p_none_due_last)
        else $error("malformed none-due result");

    property p_scan_pend;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && pend_valid_reg) |-> (pend_idx_reg < scan_reg);
    endproperty
    a_scan_pend: assert property (p_scan_pend)
        else $error("pending dispatch not ahead of scan position");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(out_reg));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result was overwritten");

endmodule

[bench/periodic_task_dispatcher_tb.sv]
`timescale 1ns / 1ps

module periodic_task_dispatcher_tb
    import ptd_pkg::*;
();

    localparam int TASK_SLOTS   = 8;
    localparam int RANDOM_CMDS  = 240;
    localparam int QUIET_TAIL   = 70;
    localparam int DRAIN_EVERY  = 60;
    localparam int SETTLE       = 200;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int N_DIRECTED   = 26;

    // opcodes the block must ignore
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    typedef struct {
        logic [2:0]  opcode;
        logic [7:0]  slot;
        logic [15:0] period;
        bit          typed;
        kind_t       kind;
        logic [2:0]  task_index;
        status_t     status;
    } cmd_row_t;

    // typed rows carry their single status/none-due result; others use the predictor
    cmd_row_t directed_rows [N_DIRECTED] = '{
        '{OP_TICK,    8'd0,   16'd0,     1'b1, KIND_NONE_DUE, 3'd0, ST_OK},
        '{OP_CREATE,  8'd0,   16'd1,     1'b1, KIND_STATUS,   3'd0, ST_OK},
        '{OP_CREATE,  8'd0,   16'hABCD,  1'b1, KIND_STATUS,   3'd0, ST_OCCUPIED},
        '{OP_CREATE,  8'd255, 16'hFFFF,  1'b1, KIND_STATUS,   3'd7, ST_RANGE},
        '{OP_DELETE,  8'd8,   16'd0,     1'b1, KIND_STATUS,   3'd0, ST_RANGE},
        '{OP_SUSPEND, 8'd128, 16'd0,     1'b1, KIND_STATUS,   3'd0, ST_RANGE},
        '{OP_RESUME,  8'd203, 16'd0,     1'b1, KIND_STATUS,   3'd3, ST_RANGE},
        '{OP_RSVD_5,  8'd3,   16'd5,     1'b0, KIND_STATUS,   3'd0, ST_OK},
        '{OP_CREATE,  8'd7,   16'hFFFF,  1'b1, KIND_STATUS,   3'd7, ST_OK},
        '{OP_CREATE,  8'd3,   16'd0,     1'b1, KIND_STATUS,   3'd3, ST_OK},
        '{OP_CREATE,  8'd1,   16'd2,     1'b1, KIND_STATUS,   3'd1, ST_OK},
        '{OP_CREATE,  8'd2,   16'd3,     1'b1, KIND_STATUS,   3'd2, ST_OK},
        '{OP_TICK,    8'd0,   16'd0,     1'b0, KIND_STATUS,   3'd0, ST_OK},
        '{OP_SUSPEND, 8'd0,   16'd0,     1'b1, KIND_STATUS,   3'd0, ST_OK},
        '{OP_TICK,    8'd0,   16'd0,     1'b0, KIND_STATUS,   3'd0, ST_OK},
        '{OP_SUSPEND, 8'd5,   16'd0,     1'b1, KIND_STATUS,   3'd5, ST_OK},
        '{OP_RESUME,  8'd6,   16'd0,     1'b1, KIND_STATUS,   3'd6, ST_OK},
        '{OP_DELETE,  8'd1,   16'd0,     1'b1, KIND_STATUS,   3'd1, ST_OK},
        '{OP_TICK,    8'd0,   16'd0,     1'b0, KIND_STATUS,   3'd0, ST_OK},
        '{OP_CREATE,  8'd1,   16'd4,     1'b1, KIND_STATUS,   3'd1, ST_OK},
        '{OP_RESUME,  8'd0,   16'd0,     1'b1, KIND_STATUS,   3'd0, ST_OK},
        '{OP_CREATE,  8'd4,   16'd1,     1'b1, KIND_STATUS,   3'd4, ST_OK},
        '{OP_CREATE,  8'd5,   16'd2,     1'b1, KIND_STATUS,   3'd5, ST_OK},
        '{OP_CREATE,  8'd6,   16'd1,     1'b1, KIND_STATUS,   3'd6, ST_OK},
        '{OP_TICK,    8'd0,   16'd0,     1'b0, KIND_STATUS,   3'd0, ST_OK},
        '{OP_TICK,    8'd0,   16'd0,     1'b0, KIND_STATUS,   3'd0, ST_OK}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptd_req_if req ();
    ptd_rsp_if rsp ();

    periodic_task_dispatcher #(.TASK_SLOTS(TASK_SLOTS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow task table
    bit          slot_live    [TASK_SLOTS];
    bit          slot_running [TASK_SLOTS];
    logic [15:0] slot_every   [TASK_SLOTS];
    logic [15:0] tick_now;

    result_t cmd_results [$];
    result_t awaited_results [$];

    bit gaps_on;
    int stall_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    function automatic void predict_command(input logic [2:0] op, input logic [7:0] sl,
                                            input logic [15:0] per);
        result_t r;
        int      i;
        cmd_results.delete();
        r.kind       = KIND_STATUS;
        r.task_index = sl[2:0];
        r.status     = ST_OK;
        r.last       = 1'b1;
        if (op == OP_TICK)
        begin
            tick_now = tick_now + 16'd1;
            for (i = 0; i < TASK_SLOTS; i++)
            begin
                // period zero never fires
                if (slot_live[i] && slot_running[i] && slot_every[i] != 16'd0 &&
                    (tick_now % slot_every[i]) == 16'd0)
                begin
                    r.kind       = KIND_DISPATCH;
                    r.task_index = i[2:0];
                    r.last       = 1'b0;
                    cmd_results.push_back(r);
                end
            end
            if (cmd_results.size() == 0)
            begin
                r.kind       = KIND_NONE_DUE;
                r.task_index = 3'd0;
                r.last       = 1'b1;
                cmd_results.push_back(r);
            end
            else
            begin
                r      = cmd_results.pop_back();
                r.last = 1'b1;
                cmd_results.push_back(r);
            end
        end
        else if (op > OP_TICK)
        begin
            // ignored, no transaction back
        end
        else if (sl >= TASK_SLOTS)
        begin
            r.status = ST_RANGE;
            cmd_results.push_back(r);
        end
        else
        begin
            case (op)
                OP_CREATE:
                begin
                    if (slot_live[sl])
                        r.status = ST_OCCUPIED;
                    else
                    begin
                        slot_live[sl]    = 1'b1;
                        slot_running[sl] = 1'b1;
                        slot_every[sl]   = per;
                    end
                end
                OP_DELETE:  slot_live[sl]    = 1'b0;
                OP_SUSPEND: slot_running[sl] = 1'b0;
                default:    slot_running[sl] = 1'b1;
            endcase
            cmd_results.push_back(r);
        end
    endfunction

    task automatic issue(input logic [2:0] op, input logic [7:0] sl, input logic [15:0] per,
                         input bit typed, input result_t typed_res);
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.slot   <= sl;
        req.period <= per;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_command(op, sl, per);
        if (typed)
            awaited_results.push_back(typed_res);
        else
            foreach (cmd_results[k])
                awaited_results.push_back(cmd_results[k]);
    endtask

    task automatic pause_sender();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 8))
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls at random, in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready  <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            rsp.ready  <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected transaction: kind %0d task_index %0d status %0d last %0d",
                       rsp.kind, rsp.task_index, rsp.status, rsp.last);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp.kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp.kind);
                    fail_count++;
                end
                if (rsp.task_index !== want.task_index)
                begin
                    $error("task_index mismatch: expected %0d, actual %0d",
                           want.task_index, rsp.task_index);
                    fail_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, rsp.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]  op;
        logic [7:0]  sl;
        logic [15:0] per;
        result_t     typed_res;
        int          issued;
        int          pick;
        int          s;

        req.valid   <= 1'b0;
        req.opcode  <= OP_TICK;
        req.slot    <= 8'd0;
        req.period  <= 16'd0;
        gaps_on     = 1'b1;
        tick_now    = 16'd0;
        for (s = 0; s < TASK_SLOTS; s++)
        begin
            slot_live[s]    = 1'b0;
            slot_running[s] = 1'b0;
            slot_every[s]   = 16'd0;
        end

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[n])
        begin
            typed_res.kind       = directed_rows[n].kind;
            typed_res.task_index = directed_rows[n].task_index;
            typed_res.status     = directed_rows[n].status;
            typed_res.last       = 1'b1;
            if ($urandom_range(0, 3) == 0)
                pause_sender();
            issue(directed_rows[n].opcode, directed_rows[n].slot, directed_rows[n].period,
                  directed_rows[n].typed, typed_res);
        end
        wait_drained();
        typed_res = '0;

        // random commands, mostly small periods so ticks dispatch often
        issued = 0;
        while (issued < RANDOM_CMDS)
        begin
            if (issued == RANDOM_CMDS - QUIET_TAIL)
                gaps_on = 1'b0;
            if (gaps_on && issued != 0 && issued % DRAIN_EVERY == 0)
                wait_drained();
            pick = $urandom_range(0, 99);
            sl   = 8'($urandom_range(0, TASK_SLOTS - 1));
            per  = 16'($urandom());
            if (pick < 35)
            begin
                op = OP_TICK;
                sl = 8'($urandom());
            end
            else if (pick < 55)
            begin
                op = OP_CREATE;
                case ($urandom_range(0, 9))
                    0:       per = 16'd0;
                    1:       per = 16'($urandom());
                    2:       per = 16'hFFFF;
                    default: per = 16'($urandom_range(1, 6));
                endcase
            end
            else if (pick < 67)
                op = OP_DELETE;
            else if (pick < 77)
                op = OP_SUSPEND;
            else if (pick < 87)
                op = OP_RESUME;
            else if (pick < 92)
                op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
            else
            begin
                op = 3'($urandom_range(OP_CREATE, OP_RESUME));
                sl = 8'($urandom_range(TASK_SLOTS, 255));
            end
            if (gaps_on && $urandom_range(0, 4) == 0)
                pause_sender();
            issue(op, sl, per, 1'b0, typed_res);
            if (op <= OP_TICK)
                issued++;
        end

        wait_drained();
        repeat (SETTLE)
            @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
